// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers. Each expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ILZSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ILZSS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/ilzss_pkg.sv =====
package ilzss_pkg;

    // Window geometry
    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int START_POS       = 'hFEE;

    // Match length field and offset
    localparam int LEN_W     = 5;
    localparam int MIN_MATCH = 3;

    // Config register width
    localparam int OLEN_W = 24;

    // Sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_COPY
    } state_t;

    // Role of an incoming byte
    typedef enum logic [2:0] {
        TOK_IGNORE,
        TOK_FLAG,
        TOK_LITERAL,
        TOK_MATCH_LO,
        TOK_MATCH_HI
    } tok_t;

    // Window port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_written;
    } win_ctl_t;

endpackage

// ===== hw/rtl/ilzss_window.sv =====
`include "assert_macros.svh"

module ilzss_window #(
    parameter int WINDOW_SIZE = ilzss_pkg::WINDOW_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ilzss_pkg::win_ctl_t            ctl,
    input  logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
    input  logic [7:0]                     wr_data,
    input  logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
    output logic [7:0]                     rd_data
);

    localparam int AW = $clog2(WINDOW_SIZE);

    logic [7:0] mem [WINDOW_SIZE];
    logic [7:0] q_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_reg;
    logic       written_reg;

    // Ring storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // Write data captured for a read of the entry being written
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // Read qualifiers: bypass hit and entry-written flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= 1'b0;
            written_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_reg     <= ctl.wr_en && (wr_addr == rd_addr);
            written_reg <= ctl.rd_written;
        end
    end

    // Unwritten entries read as zero
    always_comb
    begin
        if (fwd_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (written_reg)
        begin
            rd_data = q_reg;
        end
        else
        begin
            rd_data = 8'h00;
        end
    end

    `ILZSS_ASSERT(a_bypass_data, ctl.rd_en && ctl.wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data), "read of entry under write missed bypass")

endmodule

// ===== hw/rtl/inverted_lzss_decompressor.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------
// cfg      | cfg_valid/cfg_ready  | output_length[23:0]
// in       | in_valid/in_stall    | in_byte[7:0], in_last
// out      | out_valid/out_stall  | out_byte[7:0], run_last, stream_done
//
// Flag, first match byte and literal bytes are each taken in ST_IDLE.
// Second match byte: accepted, then ST_COPY copies up to 18 bytes
// (one window read and one write per cycle while out_stall does not hold the copy).
// Reset takes effect at once: a fill count marks which window entries
// hold data, so there is no clearing pass, also not at end of stream.
// out_stall holds the copy in place; input waits while the output register
// is full and stalled.
`include "assert_macros.svh"

module inverted_lzss_decompressor #(
    parameter int WINDOW_SIZE = ilzss_pkg::WINDOW_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ilzss_pkg::OLEN_W-1:0] output_length,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   in_byte,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic                         run_last,
    output logic                         stream_done
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int FW = AW + 1;
    localparam int LW = ilzss_pkg::LEN_W;
    localparam int OW = ilzss_pkg::OLEN_W;

    localparam logic [AW-1:0] START = AW'(ilzss_pkg::START_POS);
    localparam logic [FW-1:0] FULL  = FW'(WINDOW_SIZE);

    ilzss_pkg::state_t state_reg, state_next;
    logic [OW-1:0]     olen_reg, olen_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [15:0]       flag_reg, flag_next;
    logic [7:0]        lo_reg, lo_next;
    logic              pend_reg, pend_next;
    logic [OW-1:0]     prod_reg, prod_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [LW-1:0]     rem_reg, rem_next;
    logic              lastp_reg, lastp_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              orun_reg, orun_next;
    logic              odone_reg, odone_next;

    ilzss_pkg::tok_t     kind;
    ilzss_pkg::win_ctl_t win_ctl;
    logic [7:0]          b;
    logic [11:0]         src_full;
    logic [AW-1:0]       match_src;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       rd_ofs;
    logic [7:0]          win_rd_data;
    logic                can_emit;
    logic                accept;
    logic                hit_limit;
    logic                copy_emit;
    logic                copy_end;
    logic                lit_emit;
    logic                emit;
    logic                flush;

    // Shared decode
    assign b         = ~in_byte;
    assign can_emit  = !ovalid_reg || !out_stall;
    assign accept    = in_valid && !in_stall;
    assign hit_limit = (prod_reg + OW'(1)) == olen_reg;
    assign copy_end  = (rem_reg == LW'(1)) || hit_limit;
    assign src_full  = {b, lo_reg[7:4]};
    assign match_src = AW'(src_full);

    // Token role of the current input byte
    always_comb
    begin
        if (prod_reg >= olen_reg)
        begin
            kind = ilzss_pkg::TOK_IGNORE;
        end
        else if (pend_reg)
        begin
            kind = ilzss_pkg::TOK_MATCH_HI;
        end
        else if (!flag_reg[7])
        begin
            kind = ilzss_pkg::TOK_FLAG;
        end
        else if (flag_reg[15])
        begin
            kind = ilzss_pkg::TOK_LITERAL;
        end
        else
        begin
            kind = ilzss_pkg::TOK_MATCH_LO;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ilzss_pkg::ST_IDLE:
            begin
                if (accept && (kind == ilzss_pkg::TOK_MATCH_HI))
                begin
                    state_next = ilzss_pkg::ST_COPY;
                end
            end
            ilzss_pkg::ST_COPY:
            begin
                if (can_emit && copy_end)
                begin
                    state_next = ilzss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ilzss_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall  = 1'b1;
        copy_emit = 1'b0;
        unique case (state_reg)
            ilzss_pkg::ST_IDLE:
            begin
                in_stall = !can_emit;
            end
            ilzss_pkg::ST_COPY:
            begin
                copy_emit = can_emit;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign lit_emit = accept && (kind == ilzss_pkg::TOK_LITERAL);
    assign emit     = lit_emit || copy_emit;
    assign flush    = (accept && in_last && (kind != ilzss_pkg::TOK_MATCH_HI))
                    || (copy_emit && copy_end && lastp_reg);

    // Window access
    assign rd_addr            = (state_reg == ilzss_pkg::ST_COPY) ? src_reg : match_src;
    assign rd_ofs             = rd_addr - START;
    assign win_ctl.wr_en      = emit;
    assign win_ctl.rd_en      = (accept && (kind == ilzss_pkg::TOK_MATCH_HI))
                              || (copy_emit && !copy_end);
    assign win_ctl.rd_written = {1'b0, rd_ofs} < fill_reg;

    ilzss_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win_ctl),
        .wr_addr (wp_reg),
        .wr_data (obyte_next),
        .rd_addr (rd_addr),
        .rd_data (win_rd_data)
    );

    // Datapath next values
    always_comb
    begin
        olen_next   = olen_reg;
        wp_next     = wp_reg;
        flag_next   = flag_reg;
        lo_next     = lo_reg;
        pend_next   = pend_reg;
        prod_next   = prod_reg;
        fill_next   = fill_reg;
        src_next    = src_reg;
        rem_next    = rem_reg;
        lastp_next  = lastp_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = (state_reg == ilzss_pkg::ST_COPY) ? win_rd_data : b;
        orun_next   = orun_reg;
        odone_next  = odone_reg;

        if (cfg_valid)
        begin
            olen_next = output_length;
        end

        // token bookkeeping
        if (accept)
        begin
            unique case (kind)
                ilzss_pkg::TOK_FLAG:
                begin
                    flag_next = {b, 8'hFF};
                end
                ilzss_pkg::TOK_LITERAL:
                begin
                    flag_next = {flag_reg[14:0], 1'b0};
                end
                ilzss_pkg::TOK_MATCH_LO:
                begin
                    lo_next   = b;
                    pend_next = 1'b1;
                end
                ilzss_pkg::TOK_MATCH_HI:
                begin
                    pend_next  = 1'b0;
                    flag_next  = {flag_reg[14:0], 1'b0};
                    src_next   = match_src + AW'(1);
                    rem_next   = LW'(lo_reg[3:0]) + LW'(ilzss_pkg::MIN_MATCH);
                    lastp_next = in_last;
                end
                ilzss_pkg::TOK_IGNORE:
                begin
                    flag_next = flag_reg;
                end
                default:
                begin
                    flag_next = flag_reg;
                end
            endcase
        end

        // copy progress
        if (copy_emit)
        begin
            rem_next = rem_reg - LW'(1);
            if (!copy_end)
            begin
                src_next = src_reg + AW'(1);
            end
        end

        // byte out: window write, counters, output register
        if (emit)
        begin
            wp_next     = wp_reg + AW'(1);
            prod_next   = prod_reg + OW'(1);
            fill_next   = (fill_reg == FULL) ? fill_reg : fill_reg + FW'(1);
            ovalid_next = 1'b1;
            orun_next   = lit_emit || copy_end;
            odone_next  = hit_limit;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end

        // end of stream
        if (flush)
        begin
            wp_next   = START;
            flag_next = 16'h0000;
            pend_next = 1'b0;
            prod_next = '0;
            fill_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ilzss_pkg::ST_IDLE;
            olen_reg   <= '0;
            wp_reg     <= START;
            flag_reg   <= 16'h0000;
            pend_reg   <= 1'b0;
            prod_reg   <= '0;
            fill_reg   <= '0;
            rem_reg    <= '0;
            lastp_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            olen_reg   <= olen_next;
            wp_reg     <= wp_next;
            flag_reg   <= flag_next;
            pend_reg   <= pend_next;
            prod_reg   <= prod_next;
            fill_reg   <= fill_next;
            rem_reg    <= rem_next;
            lastp_reg  <= lastp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        src_reg <= src_next;
        if (emit)
        begin
            obyte_reg <= obyte_next;
        end
        orun_reg  <= orun_next;
        odone_reg <= odone_next;
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign run_last    = orun_reg;
    assign stream_done = odone_reg;

    `ILZSS_ASSERT(a_copy_rem, (state_reg == ilzss_pkg::ST_COPY) |-> (rem_reg != '0), "copy running with nothing left")
    `ILZSS_ASSERT_NEVER(a_emit_limit, emit && (prod_reg >= olen_reg), "byte produced past output length")
    `ILZSS_ASSERT(a_fill_bound, fill_reg <= FULL, "fill count beyond window size")

endmodule
